// File: design/ufsc_pkg.sv
// Shared types and constants for the frame sync checker.
// No dependencies; imported by ufsc_frame_check and usart_frame_sync_checker.
package ufsc_pkg;

  localparam int WIN_DEPTH = 7;
  localparam int FILL_W    = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  typedef logic [7:0]        data8_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // entry 0 is the oldest byte
  typedef data8_t [WIN_DEPTH-1:0] win_t;

  localparam cfg_idx_t CFG_HEADER = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_TAIL   = cfg_idx_t'(1);

  localparam data8_t HEADER_RESET = 8'h55;
  localparam data8_t TAIL_RESET   = 8'hbb;
  localparam fill_t  FILL_FULL    = fill_t'(WIN_DEPTH);

  typedef struct packed {
    logic         frame_ok;
    data8_t [3:0] payload;
    data8_t       address_byte;
  } res_t;

endpackage

// File: design/ufsc_frame_check.sv
// Frame match logic: header, tail and additive checksum over the window.
// Depends on ufsc_pkg.
module ufsc_frame_check
  import ufsc_pkg::*;
(
  input  win_t   window,
  input  fill_t  fill,
  input  data8_t cur_byte,
  input  data8_t header_value,
  input  data8_t tail_value,
  output res_t   res
);

  logic   full;
  data8_t sum;

  assign full = (fill >= FILL_FULL);
  assign sum  = window[2] + window[3] + window[4] + window[5];

  always_comb begin
    res = '0;
    if (full) begin
      res.address_byte = window[1];
      res.payload[0]   = window[2];
      res.payload[1]   = window[3];
      res.payload[2]   = window[4];
      res.payload[3]   = window[5];
      res.frame_ok     = (window[0] == header_value) && (cur_byte == tail_value) &&
                         (sum == window[6]);
    end
  end

endmodule

// File: design/usart_frame_sync_checker.sv
// Top level of the frame sync checker: byte window, config registers, result register.
// Depends on ufsc_pkg and ufsc_frame_check.
//
// Usage:
//   in_*  : one received byte per beat; in_tdata = rx_byte, in_tuser = burst_start.
//           burst_start clears the window before its byte is taken.
//   out_* : one result beat per input beat; out_tuser = frame_ok, out_tdata holds
//           address_byte and payload_0..payload_3.
//   cfg_* : register writes; index 0 = header_value, 1 = tail_value, others ignored.
//           cfg_ready is always high.
// Latency: a result appears on out_* the cycle after its byte is accepted.
// Throughput: one byte per cycle while out_tready keeps the result slot free; the window
// shift and a four-byte adder form the path between the window and result registers.
// Reset: window and fill count clear, header 0x55, tail 0xbb, no result pending.
// Stall: while out_tready is low a pending result holds and in_tready drops; a
// result taken in the same cycle frees the slot for the next byte at once.
module usart_frame_sync_checker
  import ufsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [7:0] rx_byte
  input  logic                 in_tuser,    // [0] burst_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,   // [7:0] address_byte, [15:8] payload_0,
                                            // [23:16] payload_1, [31:24] payload_2,
                                            // [39:32] payload_3
  output logic                 out_tuser,   // [0] frame_ok
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  win_t   window_r, window_nxt, window_eff;
  fill_t  fill_r, fill_nxt, fill_eff;
  data8_t header_r, tail_r;
  res_t   res_r, res_nxt;
  logic   out_valid_r;
  logic   in_beat;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    window_eff = in_tuser ? '0 : window_r;
    fill_eff   = in_tuser ? '0 : fill_r;
    window_nxt = {in_tdata, window_eff[WIN_DEPTH-1:1]};
    fill_nxt   = (fill_eff < FILL_FULL) ? fill_eff + fill_t'(1) : fill_eff;
  end

  ufsc_frame_check u_check (
    .window       (window_eff),
    .fill         (fill_eff),
    .cur_byte     (in_tdata),
    .header_value (header_r),
    .tail_value   (tail_r),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        window_r <= window_nxt;
        fill_r   <= fill_nxt;
      end
      if (in_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      tail_r   <= TAIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER: header_r <= cfg_data[7:0];
        CFG_TAIL:   tail_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.frame_ok;
  assign out_tdata  = {res_r.payload, res_r.address_byte};

`ifndef SYNTHESIS
  a_burst_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_tuser |=> fill_r == fill_t'(1))
    else $error("fill count not restarted by burst start");

  a_short_window_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (fill_eff < FILL_FULL) |=> !out_tuser && (out_tdata == '0))
    else $error("result from a partly filled window is not zero");

  a_stall_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(window_r) && $stable(fill_r))
    else $error("window moved while result stalled");

  a_header_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == CFG_HEADER |=> header_r == $past(cfg_data[7:0]))
    else $error("header register write lost");
`endif

endmodule

// File: bench/usart_frame_sync_checker_tb.sv
// Self-checking bench for usart_frame_sync_checker: directed table, then random frames and noise.
// Expected beats: typed table rows, else its window model; depends on ufsc_pkg and the DUT only.
module usart_frame_sync_checker_tb;
  import ufsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES       = 6;
  localparam int PHASE_BEATS    = 65;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 2;

  localparam res_t NO_FRAME = '0;
  localparam res_t FRAME_A  = res_t'{frame_ok: 1'b1, payload: {8'h40, 8'h30, 8'h20, 8'h10},
                                     address_byte: 8'hA1};
  localparam res_t FRAME_B  = res_t'{frame_ok: 1'b1, payload: {8'h81, 8'h80, 8'hFF, 8'hFF},
                                     address_byte: 8'h00};

  typedef struct {
    data8_t rx;
    logic   start;
    bit     typed;
    res_t   want;
  } dir_row_t;

  dir_row_t dir_tab [24] = '{
    '{8'h55, 1'b1, 1'b1, NO_FRAME}, '{8'hA1, 1'b0, 1'b1, NO_FRAME},
    '{8'h10, 1'b0, 1'b1, NO_FRAME}, '{8'h20, 1'b0, 1'b1, NO_FRAME},
    '{8'h30, 1'b0, 1'b1, NO_FRAME}, '{8'h40, 1'b0, 1'b1, NO_FRAME},
    '{8'hA0, 1'b0, 1'b1, NO_FRAME}, '{8'hBB, 1'b0, 1'b1, FRAME_A},
    '{8'h55, 1'b1, 1'b1, NO_FRAME}, '{8'h00, 1'b0, 1'b1, NO_FRAME},
    '{8'hFF, 1'b0, 1'b1, NO_FRAME}, '{8'hFF, 1'b0, 1'b1, NO_FRAME},
    '{8'h80, 1'b0, 1'b1, NO_FRAME}, '{8'h81, 1'b0, 1'b1, NO_FRAME},
    '{8'hFF, 1'b0, 1'b1, NO_FRAME}, '{8'hBB, 1'b0, 1'b1, FRAME_B},
    '{8'h55, 1'b0, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, 1'b0, NO_FRAME}, '{8'h00, 1'b0, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, 1'b0, NO_FRAME},
    '{8'hBB, 1'b0, 1'b0, NO_FRAME}, '{8'h00, 1'b1, 1'b1, NO_FRAME}
  };

  data8_t hdr_set  [N_PHASES] = '{8'h55, 8'h00, 8'hFF, 8'h7E, 8'h00, 8'hFF};
  data8_t tail_set [N_PHASES] = '{8'hBB, 8'hFF, 8'h00, 8'h7E, 8'h00, 8'hFF};

  logic           clk;
  logic           rst_n      = 1'b0;
  logic           in_tvalid  = 1'b0;
  logic           in_tready;
  logic [7:0]     in_tdata   = '0;   // [7:0] rx_byte
  logic           in_tuser   = 1'b0; // [0] burst_start
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [39:0]    out_tdata;         // [7:0] address, [15:8]..[39:32] payload_0..3
  logic           out_tuser;         // [0] frame_ok
  logic           cfg_valid  = 1'b0;
  logic           cfg_ready;
  cfg_idx_t       cfg_index  = '0;
  logic [7:0]     cfg_data   = '0;

  // window model
  win_t   win_bytes;
  int     win_fill;
  data8_t hdr_reg;
  data8_t tail_reg;

  res_t   frame_q [$];
  bit     row_typed = 1'b0;
  res_t   row_want  = '0;

  int snd_idle_pct = 33;
  int rcv_idle_pct = 48;
  int rx_hold_len  = 0;
  int beats_sent   = 0;
  int n_in = 0, n_out = 0, n_frames = 0, n_settings = 1;
  int err_cnt = 0;
  int idle_cycles = 0;

  usart_frame_sync_checker u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic res_t predict_frame(data8_t cur);
    res_t   r;
    data8_t sum;
    r = '0;
    if (win_fill >= WIN_DEPTH) begin
      sum = win_bytes[2] + win_bytes[3] + win_bytes[4] + win_bytes[5];
      r.frame_ok     = (win_bytes[0] == hdr_reg) && (cur == tail_reg) && (sum == win_bytes[6]);
      r.address_byte = win_bytes[1];
      for (int i = 0; i < 4; i++) r.payload[i] = win_bytes[2 + i];
    end
    return r;
  endfunction

  // scoreboard: check result beats, then predict for the accepted byte
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (frame_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        want = frame_q.pop_front();
        if (out_tuser !== want.frame_ok) begin
          $error("frame_ok: expected %0d, got %0d", want.frame_ok, out_tuser);
          err_cnt++;
        end
        if (out_tdata[7:0] !== want.address_byte) begin
          $error("address_byte: expected %02h, got %02h", want.address_byte, out_tdata[7:0]);
          err_cnt++;
        end
        for (int i = 0; i < 4; i++)
          if (out_tdata[8 + 8*i +: 8] !== want.payload[i]) begin
            $error("payload_%0d: expected %02h, got %02h", i, want.payload[i],
                   out_tdata[8 + 8*i +: 8]);
            err_cnt++;
          end
        if (out_tuser === 1'b1) n_frames++;
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      n_in++;
      if (in_tuser) begin
        win_bytes = '0;
        win_fill  = 0;
      end
      want = predict_frame(in_tdata);
      frame_q.push_back(row_typed ? row_want : want);
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[WIN_DEPTH - 1] = in_tdata;
      if (win_fill < WIN_DEPTH) win_fill++;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        out_tready <= 1'b0;
        rx_hold_len--;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(input data8_t b, input logic s, input bit typed = 1'b0,
                           input res_t want = '0);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input data8_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HEADER) hdr_reg = val;
    else if (idx == CFG_TAIL) tail_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one frame with random content, sometimes corrupted or cut by a burst start
  task automatic send_frame(input bit share_hdr);
    data8_t fb [8];
    logic   s;
    fb[0] = hdr_reg;
    for (int i = 1; i < 6; i++) fb[i] = data8_t'($urandom);
    fb[6] = fb[2] + fb[3] + fb[4] + fb[5];
    fb[7] = tail_reg;
    if ($urandom_range(3) == 0) fb[$urandom_range(7)] ^= data8_t'(1 << $urandom_range(7));
    for (int i = share_hdr ? 1 : 0; i < 8; i++) begin
      s = (i == 0) ? ($urandom_range(3) == 0) : ($urandom_range(31) == 0);
      send_beat(fb[i], s);
    end
  endtask

  initial begin
    int  phase_end;
    bit  last_frame;
    win_bytes = '0;
    win_fill  = 0;
    hdr_reg   = HEADER_RESET;
    tail_reg  = TAIL_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_beat(dir_tab[i].rx, dir_tab[i].start, dir_tab[i].typed,
                                   dir_tab[i].want);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      snd_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 48 : 0;
      rcv_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 33 : 0;
      if (ph == 4) begin
        hdr_set[ph]  = data8_t'($urandom);
        tail_set[ph] = data8_t'($urandom);
      end
      write_reg(CFG_HEADER, hdr_set[ph]);
      write_reg(CFG_TAIL, tail_set[ph]);
      write_reg(cfg_idx_t'($urandom_range(CFG_TAIL + 1, 255)), data8_t'($urandom));
      n_settings++;
      if (ph == 1) rx_hold_len = HOLD_CYCLES;
      last_frame = 1'b0;
      phase_end  = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if (ph == 3 && beats_sent >= phase_end - PHASE_BEATS / 2 && beats_sent < phase_end - 30)
          wait_idle();
        if ($urandom_range(9) < 7) begin
          send_frame(last_frame && hdr_reg == tail_reg && $urandom_range(1));
          last_frame = 1'b1;
        end else begin
          repeat ($urandom_range(1, 4)) send_beat(data8_t'($urandom), $urandom_range(9) == 0);
          last_frame = 1'b0;
        end
      end
      wait_idle();
    end

    if (frame_q.size() != 0) begin
      $error("%0d expected results never arrived", frame_q.size());
      err_cnt++;
    end
    $display("Sent %0d bytes, checked %0d result beats, %0d matched frames,", n_in, n_out,
             n_frames);
    $display("over %0d header/tail settings with sender and receiver stalls.", n_settings);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
